@@ design/buddy_block_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication under reset
`define BBA_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("allocator check failed");

// next-cycle implication under reset
`define BBA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("allocator check failed");

`endif

@@ design/bba_pkg.sv @@
// Types and constants of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

    localparam logic [1:0]  STATUS_OK    = 2'd0;
    localparam logic [1:0]  STATUS_NULL  = 2'd1;
    localparam logic [1:0]  STATUS_NOMEM = 2'd2;

    localparam logic        ACT_ALLOC    = 1'b0;
    localparam logic        ACT_FREE     = 1'b1;

    localparam logic [4:0]  SHIFT_MAX    = 5'd16;
    localparam logic [4:0]  SHIFT_RESET  = 5'd4;
    localparam logic [24:0] FREE_CAP     = 25'h1FFFFFF;

    typedef struct packed {
        logic        action;
        logic [23:0] request_size;
        logic [23:0] block_offset;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] granted_offset;
        logic [24:0] free_bytes;
    } result_t;

endpackage

@@ design/bba_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bba_find.sv @@
// Two-level pipelined search for the lowest set bit of a tree row.
`timescale 1ns / 1ps
module bba_find #(
    parameter int TOP_ORDER = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [(1<<TOP_ORDER)-1:0] row,
    output logic                      done,
    output logic                      found,
    output logic [TOP_ORDER-1:0]      index
);

    localparam int W    = 1 << TOP_ORDER;
    localparam int HI   = TOP_ORDER / 2;
    localparam int LO   = TOP_ORDER - HI;
    localparam int NG   = 1 << HI;
    localparam int GWID = 1 << LO;
    localparam int GIW  = (HI > 0) ? HI : 1;

    logic [W-1:0]    row_reg;
    logic [NG-1:0]   gany_reg;
    logic [GWID-1:0] gbits_reg;
    logic [GIW-1:0]  gi_reg;
    logic            any_reg;
    logic            v1_reg;
    logic            v2_reg;

    logic [NG-1:0]   gany;
    logic [GIW-1:0]  gi;
    logic [LO-1:0]   li;
    logic [GWID-1:0] gbits;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            gany[g] = |row[g*GWID +: GWID];
        end
    end

    always_comb
    begin
        gi = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (gany_reg[g])
            begin
                gi = GIW'(g);
            end
        end
        gbits = GWID'(row_reg >> (int'(gi) * GWID));
    end

    always_comb
    begin
        li = '0;
        for (int b = GWID - 1; b >= 0; b--)
        begin
            if (gbits_reg[b])
            begin
                li = LO'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg  <= row;
            gany_reg <= gany;
        end
        if (v1_reg)
        begin
            gbits_reg <= gbits;
            gi_reg    <= gi;
            any_reg   <= |gany_reg;
        end
    end

    assign done  = v2_reg;
    assign found = any_reg;
    assign index = (TOP_ORDER'(gi_reg) << LO) | TOP_ORDER'(li);

endmodule

@@ design/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: sequencer over a per-depth flag RAM.
//
//  channel   direction  handshake            beat
//  command   in         start & !busy        cmd (action, request_size, block_offset)
//  result    out        result_valid pulse   result (status, granted_offset, free_bytes)
//  config    in         cfg_we               cfg_wdata (min_block_shift)
//
// One command at a time; busy stays high until its result has been issued.
// An allocate reads and searches one depth at a time from the target depth toward the
// root, then splits the found block back down to the target depth one level at a time;
// a free checks every depth, all TOP_ORDER+1 of them, for an overlapping block, then
// merges with free buddies one level at a time.
// The flag RAM holds one row per tree depth; each row is read, modified and written.
// Reset and config writes mark all rows stale; a stale row reads as its reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "buddy_block_allocator_assert.svh"
module buddy_block_allocator #(
    parameter int TOP_ORDER = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bba_pkg::cmd_t   cmd,
    input  logic            cfg_we,
    input  logic [4:0]      cfg_wdata,
    output logic            result_valid,
    output bba_pkg::result_t result
);

    import bba_pkg::*;

    localparam int W     = 1 << TOP_ORDER;
    localparam int DEPTH = TOP_ORDER + 1;
    localparam int DW    = $clog2(DEPTH);
    localparam int PW    = TOP_ORDER;
    localparam int TW    = TOP_ORDER + 17;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_ARD  = 4'd2;
    localparam logic [3:0] S_ADAT = 4'd3;
    localparam logic [3:0] S_AWT  = 4'd4;
    localparam logic [3:0] S_ACLR = 4'd5;
    localparam logic [3:0] S_SRD  = 4'd6;
    localparam logic [3:0] S_SDAT = 4'd7;
    localparam logic [3:0] S_FRD  = 4'd8;
    localparam logic [3:0] S_FDAT = 4'd9;
    localparam logic [3:0] S_FEND = 4'd10;
    localparam logic [3:0] S_MRD  = 4'd11;
    localparam logic [3:0] S_MDAT = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]    state_reg;
    cmd_t          item_reg;
    logic [4:0]    shift_reg;
    logic [TW-1:0] total_reg;
    logic [DEPTH-1:0] row_valid_reg;
    logic [DW-1:0] rd_row_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] td_reg;
    logic [DW-1:0] r_reg;
    logic [PW-1:0] p_reg;
    logic [5:0]    bs_reg;
    logic          conflict_reg;
    logic [W-1:0]  row_reg;
    logic [1:0]    status_reg;
    logic [23:0]   granted_reg;
    result_t       result_reg;
    logic          result_valid_reg;

    logic [4:0]    eff_shift;
    logic [4:0]    cfg_eff;
    logic [23:0]   size_m1;
    logic [5:0]    lg;
    logic [5:0]    diff;
    logic          k_over;
    logic [5:0]    k_calc;
    logic [5:0]    bs_calc;
    logic [5:0]    arena_sh;
    logic [31:0]   off32;
    logic          free_ok;
    logic [PW-1:0] p_calc;
    logic [DW-1:0] td_calc;

    logic          ram_we;
    logic [DW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic          ram_re;
    logic [DW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;
    logic [W-1:0]  rdata_eff;

    logic          find_start;
    logic          find_done;
    logic          find_found;
    logic [PW-1:0] find_index;

    logic [W-1:0]  hit_mask;
    logic          hit;
    logic          merge;
    logic [PW-1:0] p_buddy;
    logic [31:0]   tot32;
    logic [24:0]   free_sat;

    assign eff_shift = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
    assign cfg_eff   = (cfg_wdata > SHIFT_MAX) ? SHIFT_MAX : cfg_wdata;

    always_comb
    begin
        size_m1 = item_reg.request_size - 24'd1;
        lg = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (size_m1[i])
            begin
                lg = 6'(i + 1);
            end
        end
        if (item_reg.request_size <= 24'd1)
        begin
            lg = '0;
        end
        diff    = (lg > {1'b0, eff_shift}) ? (lg - {1'b0, eff_shift}) : 6'd0;
        k_over  = diff > 6'(TOP_ORDER);
        k_calc  = k_over ? 6'(TOP_ORDER + 1) : diff;
        bs_calc = {1'b0, eff_shift} + k_calc;
        td_calc = DW'(6'(TOP_ORDER) - k_calc);
        arena_sh = 6'(TOP_ORDER) + {1'b0, eff_shift};
        off32   = {8'd0, item_reg.block_offset};
        free_ok = !k_over && ((off32 >> arena_sh) == 32'd0)
                  && ((off32 & ((32'd1 << bs_calc) - 32'd1)) == 32'd0);
        p_calc  = PW'(off32 >> bs_calc);
    end

    assign rdata_eff = row_valid_reg[rd_row_reg] ? ram_rdata
                     : ((rd_row_reg == '0) ? W'(1) : '0);

    always_comb
    begin
        for (int q = 0; q < W; q++)
        begin
            logic [PW-1:0] qa;
            logic [PW-1:0] pa;
            qa = PW'(q) >> ((r_reg > d_reg) ? (r_reg - d_reg) : DW'(0));
            pa = p_reg >> ((d_reg > r_reg) ? (d_reg - r_reg) : DW'(0));
            hit_mask[q] = (qa == pa);
        end
        hit = |(rdata_eff & hit_mask);
    end

    assign p_buddy = p_reg ^ PW'(1);
    assign merge   = (d_reg != '0) && rdata_eff[p_buddy];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = d_reg;
        ram_wdata = rdata_eff;
        ram_re    = 1'b0;
        ram_raddr = d_reg;
        find_start = 1'b0;
        case (state_reg)
            S_ARD:
            begin
                ram_re = 1'b1;
            end
            S_ADAT:
            begin
                find_start = 1'b1;
            end
            S_ACLR:
            begin
                ram_we    = 1'b1;
                ram_wdata = row_reg & ~(W'(1) << p_reg);
            end
            S_SRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = d_reg + DW'(1);
            end
            S_SDAT:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata_eff | (W'(1) << (p_reg | PW'(1)));
            end
            S_FRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = r_reg;
            end
            S_MRD:
            begin
                ram_re = 1'b1;
            end
            S_MDAT:
            begin
                ram_we    = 1'b1;
                ram_wdata = merge ? (rdata_eff & ~(W'(1) << p_buddy))
                                  : (rdata_eff | (W'(1) << p_reg));
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign tot32    = 32'(total_reg);
    assign free_sat = (tot32 > 32'(FREE_CAP)) ? FREE_CAP : tot32[24:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            shift_reg        <= SHIFT_RESET;
            total_reg        <= TW'(1) << (TOP_ORDER + 4);
            row_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (state_reg == S_DONE);
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (item_reg.action == ACT_ALLOC)
                    begin
                        if (item_reg.request_size == 24'd0 || k_over)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_ARD;
                        end
                    end
                    else if (free_ok)
                    begin
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_ARD:
                begin
                    state_reg <= S_ADAT;
                end
                S_ADAT:
                begin
                    state_reg <= S_AWT;
                end
                S_AWT:
                begin
                    if (find_done)
                    begin
                        if (find_found)
                        begin
                            state_reg <= S_ACLR;
                        end
                        else if (d_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_ARD;
                        end
                    end
                end
                S_ACLR:
                begin
                    if (d_reg == td_reg)
                    begin
                        total_reg <= total_reg - (TW'(1) << bs_reg);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SRD;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SDAT;
                end
                S_SDAT:
                begin
                    if (d_reg == td_reg)
                    begin
                        total_reg <= total_reg - (TW'(1) << bs_reg);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SRD;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FDAT;
                end
                S_FDAT:
                begin
                    if (r_reg == DW'(TOP_ORDER))
                    begin
                        state_reg <= S_FEND;
                    end
                    else
                    begin
                        state_reg <= S_FRD;
                    end
                end
                S_FEND:
                begin
                    if (conflict_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        total_reg <= total_reg + (TW'(1) << bs_reg);
                        state_reg <= S_MRD;
                    end
                end
                S_MRD:
                begin
                    state_reg <= S_MDAT;
                end
                S_MDAT:
                begin
                    state_reg <= merge ? S_MRD : S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_we)
            begin
                shift_reg     <= cfg_wdata;
                total_reg     <= TW'(1) << (TOP_ORDER + int'(cfg_eff));
                row_valid_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rd_row_reg <= ram_raddr;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_reg <= cmd;
                end
            end
            S_PREP:
            begin
                granted_reg  <= '0;
                bs_reg       <= bs_calc;
                td_reg       <= td_calc;
                d_reg        <= td_calc;
                p_reg        <= p_calc;
                r_reg        <= '0;
                conflict_reg <= 1'b0;
                if (item_reg.action == ACT_ALLOC && item_reg.request_size == 24'd0)
                begin
                    status_reg <= STATUS_NULL;
                end
                else if (item_reg.action == ACT_ALLOC && k_over)
                begin
                    status_reg <= STATUS_NOMEM;
                end
                else
                begin
                    status_reg <= STATUS_OK;
                end
            end
            S_ADAT:
            begin
                row_reg <= rdata_eff;
            end
            S_AWT:
            begin
                if (find_done)
                begin
                    if (find_found)
                    begin
                        p_reg <= find_index;
                    end
                    else if (d_reg == '0)
                    begin
                        status_reg <= STATUS_NOMEM;
                    end
                    else
                    begin
                        d_reg <= d_reg - DW'(1);
                    end
                end
            end
            S_ACLR, S_SDAT:
            begin
                if (d_reg == td_reg)
                begin
                    granted_reg <= 24'(32'(p_reg) << bs_reg);
                end
            end
            S_SRD:
            begin
                d_reg <= d_reg + DW'(1);
                p_reg <= p_reg << 1;
            end
            S_FDAT:
            begin
                conflict_reg <= conflict_reg | hit;
                r_reg        <= r_reg + DW'(1);
            end
            S_MDAT:
            begin
                if (merge)
                begin
                    d_reg <= d_reg - DW'(1);
                    p_reg <= p_reg >> 1;
                end
            end
            S_DONE:
            begin
                result_reg.status         <= status_reg;
                result_reg.granted_offset <= granted_reg;
                result_reg.free_bytes     <= free_sat;
            end
            default:
            begin
                row_reg <= row_reg;
            end
        endcase
    end

    bba_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_find #(
        .TOP_ORDER (TOP_ORDER)
    ) u_find (
        .clk   (clk),
        .rst_n (rst_n),
        .start (find_start),
        .row   (rdata_eff),
        .done  (find_done),
        .found (find_found),
        .index (find_index)
    );

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `BBA_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid_reg, !result_valid_reg)
    `BBA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `BBA_ASSERT_SAME(a_fail_no_offset, clk, rst_n,
        result_valid_reg && (result_reg.status != STATUS_OK), result_reg.granted_offset == 24'd0)
    `BBA_ASSERT_SAME(a_no_rw_overlap, clk, rst_n, ram_we, !ram_re)

endmodule
